// ===== rtl/core/qtbh_pkg.sv =====
// Shared constants and types for the byte quantizer with histogram.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package qtbh_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_BINS = 256;
  localparam int BIN_AW   = 8;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 64;
  localparam int PADDR_W  = 3;

  localparam logic [BIN_AW-1:0] BYTE_MAX = 8'd255;

  // request opcodes
  localparam logic OP_QUANT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_MIN   = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  // request leaving the quantizer, entering the histogram
  typedef struct packed {
    logic              vld;
    logic              op;
    logic [BIN_AW-1:0] addr;
    logic [BIN_AW-1:0] qv;
  } qtbh_req_t;

  // result leaving the histogram
  typedef struct packed {
    logic              vld;
    logic [BIN_AW-1:0] qv;
    logic [DATA_W-1:0] cnt;
  } qtbh_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/qtbh_quant.sv =====
// Quantizer datapath: subtract minimum, scale multiply, clamp to a byte.
// Two register stages; depends on qtbh_pkg.
`default_nettype none

module qtbh_quant #(
  parameter int FRAC_BITS = qtbh_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 adv,
  input  wire                                 in_vld,
  input  wire                                 in_op,
  input  wire        [qtbh_pkg::DATA_W-1:0]   in_sample,
  input  wire        [qtbh_pkg::BIN_AW-1:0]   in_idx,
  input  wire        [qtbh_pkg::DATA_W-1:0]   range_min,
  input  wire        [qtbh_pkg::DATA_W-1:0]   range_scale,
  output qtbh_pkg::qtbh_req_t                 req
);

  localparam int SHIFT = 2 * FRAC_BITS;

  logic                          s1_vld_r;
  logic                          s1_op_r;
  logic [qtbh_pkg::DATA_W-1:0]   s1_dmag_r;
  logic [qtbh_pkg::BIN_AW-1:0]   s1_idx_r;

  logic                          s2_vld_r;
  logic                          s2_op_r;
  logic [qtbh_pkg::PROD_W-1:0]   s2_prod_r;
  logic [qtbh_pkg::BIN_AW-1:0]   s2_idx_r;

  logic [qtbh_pkg::DATA_W:0]     diff;
  logic                          diff_pos;
  logic [qtbh_pkg::DATA_W-1:0]   dmag_nxt;
  logic [qtbh_pkg::PROD_W-1:0]   whole;
  logic [qtbh_pkg::BIN_AW-1:0]   byte_q;

  // 33-bit signed difference; anything not strictly positive quantizes to 0
  assign diff     = {in_sample[qtbh_pkg::DATA_W-1], in_sample}
                  - {range_min[qtbh_pkg::DATA_W-1], range_min};
  assign diff_pos = !diff[qtbh_pkg::DATA_W] && (|diff[qtbh_pkg::DATA_W-1:0]);
  assign dmag_nxt = diff_pos ? diff[qtbh_pkg::DATA_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= in_op;
      s1_dmag_r <= dmag_nxt;
      s1_idx_r  <= in_idx;
      s2_op_r   <= s1_op_r;
      s2_prod_r <= qtbh_pkg::PROD_W'(s1_dmag_r) * qtbh_pkg::PROD_W'(range_scale);
      s2_idx_r  <= s1_idx_r;
    end
  end

  // integer part of the product, saturated to a byte
  assign whole  = s2_prod_r >> SHIFT;
  assign byte_q = (|whole[qtbh_pkg::PROD_W-1:qtbh_pkg::BIN_AW]) ? qtbh_pkg::BYTE_MAX
                                                                : whole[qtbh_pkg::BIN_AW-1:0];

  always_comb begin
    req.vld  = s2_vld_r;
    req.op   = s2_op_r;
    req.addr = (s2_op_r == qtbh_pkg::OP_READ) ? s2_idx_r : byte_q;
    req.qv   = (s2_op_r == qtbh_pkg::OP_READ) ? '0 : byte_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/qtbh_hist.sv =====
// Histogram store: 256-bin memory with per-bin valid bits, read-modify-write
// with one-deep write forwarding and saturating increment. Depends on qtbh_pkg.
`default_nettype none

module qtbh_hist #(
  parameter int COUNT_WIDTH = qtbh_pkg::COUNT_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  qtbh_pkg::qtbh_req_t   req,
  output qtbh_pkg::qtbh_rsp_t   rsp
);

  logic [COUNT_WIDTH-1:0]        bins_mem [qtbh_pkg::NUM_BINS];
  logic [qtbh_pkg::NUM_BINS-1:0] bin_vld_r;

  logic [COUNT_WIDTH-1:0]        rdata_r;
  logic                          rd_vld_r;

  logic                          s3_vld_r;
  logic                          s3_op_r;
  logic [qtbh_pkg::BIN_AW-1:0]   s3_addr_r;
  logic [qtbh_pkg::BIN_AW-1:0]   s3_qv_r;

  // last write, for a read that raced it
  logic                          lw_vld_r;
  logic [qtbh_pkg::BIN_AW-1:0]   lw_addr_r;
  logic [COUNT_WIDTH-1:0]        lw_data_r;

  logic                          is_quant;
  logic                          wr_en;
  logic [COUNT_WIDTH-1:0]        cur;
  logic [COUNT_WIDTH-1:0]        upd;
  logic [COUNT_WIDTH-1:0]        res_cnt;
  logic [63:0]                   cnt_ext;

  assign is_quant = s3_vld_r && (s3_op_r == qtbh_pkg::OP_QUANT);
  assign wr_en    = adv && is_quant;

  always_comb begin
    if (lw_vld_r && (lw_addr_r == s3_addr_r)) begin
      cur = lw_data_r;
    end else if (rd_vld_r) begin
      cur = rdata_r;
    end else begin
      cur = '0;
    end
  end

  assign upd     = (&cur) ? cur : cur + COUNT_WIDTH'(1);
  assign res_cnt = (s3_op_r == qtbh_pkg::OP_QUANT) ? upd : cur;
  assign cnt_ext = 64'(res_cnt);

  always_comb begin
    rsp.vld = s3_vld_r;
    rsp.qv  = s3_qv_r;
    rsp.cnt = cnt_ext[qtbh_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        bins_mem[s3_addr_r] <= upd;
      end
      rdata_r <= bins_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
      s3_vld_r  <= 1'b0;
      lw_vld_r  <= 1'b0;
    end else if (adv) begin
      if (wr_en) begin
        bin_vld_r[s3_addr_r] <= 1'b1;
      end
      s3_vld_r <= req.vld;
      lw_vld_r <= is_quant;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_vld_r  <= bin_vld_r[req.addr];
      s3_op_r   <= req.op;
      s3_addr_r <= req.addr;
      s3_qv_r   <= req.qv;
      lw_addr_r <= s3_addr_r;
      lw_data_r <= upd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/quantize_to_byte_with_histogram.sv =====
// Top level: handshake, configuration registers, output register.
// Instantiates qtbh_quant and qtbh_hist; depends on qtbh_pkg.
//
// Each request either quantizes a signed fixed-point sample to a byte and
// bumps that byte's histogram bin (op 0), or reads one bin (op 1). The block
// takes one request per clock while the output register is not stalled. The
// accepting edge loads the subtract stage; the multiply, histogram read and
// output registers are loaded after it, in that order. The whole pipeline
// stalls only while a finished result is not taken. The histogram is a single
// memory, read and written at most once per cycle while the pipeline moves; a
// bin written by the previous request is forwarded, so back-to-back hits on
// the same bin cost nothing. All bins read as zero right after reset, with no
// clearing pass. Program range_minimum and range_scale only while idle.
`default_nettype none

module quantize_to_byte_with_histogram #(
  parameter int COUNT_WIDTH = qtbh_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = qtbh_pkg::FRAC_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,

  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_op,
  input  wire        [qtbh_pkg::DATA_W-1:0]  in_sample_value,
  input  wire        [qtbh_pkg::BIN_AW-1:0]  in_bin_index,

  output logic                               out_valid,
  input  wire                                out_ready,
  output logic       [qtbh_pkg::BIN_AW-1:0]  out_quantized_value,
  output logic       [qtbh_pkg::DATA_W-1:0]  out_bin_count,

  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire        [qtbh_pkg::PADDR_W-1:0] paddr,
  input  wire        [qtbh_pkg::DATA_W-1:0]  pwdata,
  output logic       [qtbh_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam logic [qtbh_pkg::DATA_W-1:0] SCALE_ONE = qtbh_pkg::DATA_W'(1) << FRAC_BITS;

  logic [qtbh_pkg::DATA_W-1:0] range_min_r;
  logic [qtbh_pkg::DATA_W-1:0] range_scale_r;

  logic                        out_valid_r;
  logic [qtbh_pkg::BIN_AW-1:0] out_qv_r;
  logic [qtbh_pkg::DATA_W-1:0] out_cnt_r;

  logic                        adv;
  logic                        cfg_wr;
  logic                        reg_sel;

  qtbh_pkg::qtbh_req_t         req;
  qtbh_pkg::qtbh_rsp_t         rsp;

  // the pipeline moves whenever the output register is free or being drained
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= '0;
      range_scale_r <= SCALE_ONE;
    end else if (cfg_wr) begin
      case (reg_sel)
        qtbh_pkg::REG_MIN:   range_min_r   <= pwdata;
        qtbh_pkg::REG_SCALE: range_scale_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      qtbh_pkg::REG_MIN:   prdata = range_min_r;
      qtbh_pkg::REG_SCALE: prdata = range_scale_r;
      default:             prdata = '0;
    endcase
  end

  qtbh_quant #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quant (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (in_valid),
    .in_op       (in_op),
    .in_sample   (in_sample_value),
    .in_idx      (in_bin_index),
    .range_min   (range_min_r),
    .range_scale (range_scale_r),
    .req         (req)
  );

  qtbh_hist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rsp.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_qv_r  <= rsp.qv;
      out_cnt_r <= rsp.cnt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_quantized_value = out_qv_r;
  assign out_bin_count       = out_cnt_r;

endmodule

`default_nettype wire
